// ===== hdl/key_matrix_hid_report_packer_unit_macros.svh =====
// Assertion macros for the report packer checker.
`ifndef KEY_MATRIX_HID_REPORT_PACKER_UNIT_MACROS_SVH
`define KEY_MATRIX_HID_REPORT_PACKER_UNIT_MACROS_SVH

// Check on every clock edge outside reset.
`define KMHR_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("kmhr check failed");

// Check on every clock edge, reset included.
`define KMHR_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("kmhr reset check failed");

`endif

// ===== hdl/kmhr_pkg.sv =====
package kmhr_pkg;

  localparam int KMHR_COLUMNS = 14;
  localparam int KMHR_ROWS    = 5;
  localparam int REPORT_KEYS  = 6;
  localparam int ROW_BITS_W   = 5;
  localparam int KEY_CNT_W    = 3;
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_W    = 2;
  localparam int OUT_CNT_W    = 3;

  localparam logic KIND_MAP_WRITE = 1'b0;
  localparam logic KIND_COLUMN    = 1'b1;

  localparam logic REPORT_KEY     = 1'b0;
  localparam logic REPORT_RELEASE = 1'b1;

  localparam logic [4:0] MOD_PREFIX = 5'b11100;

  typedef logic [REPORT_KEYS-1:0][7:0] key_slots_t;

  typedef struct packed {
    logic       report_type;
    logic [7:0] modifier_bits;
    key_slots_t key_slots;
    logic       final_result;
  } report_t;

  typedef struct packed {
    logic [1:0] count;
    report_t    rep0;
    report_t    rep1;
  } push_t;

  typedef struct packed {
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last_column;
    logic                  in_range;
  } col_item_t;

endpackage

// ===== hdl/kmhr_keymap.sv =====
module kmhr_keymap #(
  parameter int COLUMNS = kmhr_pkg::KMHR_COLUMNS,
  parameter int ROWS    = kmhr_pkg::KMHR_ROWS
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [6:0]           wr_index,
  input  logic [7:0]           wr_code,
  input  logic                 rd_en,
  input  logic [3:0]           rd_column,
  output logic [ROWS-1:0][7:0] rd_codes
);
  import kmhr_pkg::*;

  localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  logic [ROWS-1:0][7:0] mem [COLUMNS];

  logic [8:0]       idx_ext;
  logic [8:0]       row_full;
  logic [COL_W-1:0] wr_col;
  logic [ROW_W-1:0] wr_row;
  logic             wr_ok;
  logic [5:0]       rd_col_ext;
  logic [COL_W-1:0] rd_addr;

  always_comb begin
    idx_ext = 9'(wr_index);
    wr_col  = '0;
    for (int c = 1; c < COLUMNS; c++) begin
      if (idx_ext >= 9'(c * ROWS)) begin
        wr_col = COL_W'(c);
      end
    end
    row_full = idx_ext - 9'(wr_col) * 9'(ROWS);
    wr_row   = row_full[ROW_W-1:0];
    wr_ok    = idx_ext < 9'(COLUMNS * ROWS);
  end

  assign rd_col_ext = 6'(rd_column);
  assign rd_addr    = (rd_col_ext < 6'(COLUMNS)) ? rd_col_ext[COL_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_col][wr_row] <= wr_code;
    end
    if (rd_en) begin
      rd_codes <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/kmhr_core.sv =====
module kmhr_core #(
  parameter int ROWS = kmhr_pkg::KMHR_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  kmhr_pkg::col_item_t  item,
  input  logic [ROWS-1:0][7:0] codes,
  output kmhr_pkg::push_t      push
);
  import kmhr_pkg::*;

  localparam int SCAN_ROWS = (ROWS < ROW_BITS_W) ? ROWS : ROW_BITS_W;

  key_slots_t           key_buffer;
  logic [KEY_CNT_W-1:0] key_count;
  logic [7:0]           modifier_acc;
  logic                 any_pressed_this_scan;
  logic                 pressed_last_scan;

  key_slots_t           buf_w;
  logic [KEY_CNT_W-1:0] cnt_w;
  logic [7:0]           mods_w;
  logic                 any_w;
  logic [7:0]           code_w;
  logic                 full_emit;
  logic                 left_emit;
  logic                 rel_emit;
  report_t              full_rep;
  report_t              left_rep;
  report_t              rel_rep;
  logic [1:0]           n_w;

  always_comb begin
    buf_w     = key_buffer;
    cnt_w     = key_count;
    mods_w    = modifier_acc;
    any_w     = any_pressed_this_scan;
    code_w    = '0;
    full_emit = 1'b0;
    full_rep  = '0;
    for (int r = 0; r < SCAN_ROWS; r++) begin
      if (item.in_range && item.row_bits[r]) begin
        code_w = codes[r];
        if (code_w[7:3] == MOD_PREFIX) begin
          mods_w = mods_w | (8'd1 << code_w[2:0]);
        end
        buf_w[cnt_w] = code_w;
        cnt_w = cnt_w + 1'b1;
        if (cnt_w == KEY_CNT_W'(REPORT_KEYS)) begin
          full_emit              = 1'b1;
          full_rep.report_type   = REPORT_KEY;
          full_rep.modifier_bits = mods_w;
          full_rep.key_slots     = buf_w;
          cnt_w = '0;
          buf_w = '0;
        end
        any_w = 1'b1;
      end
    end

    left_emit = item.last_column && (cnt_w != '0);
    rel_emit  = item.last_column && !any_w && pressed_last_scan;

    left_rep               = '0;
    left_rep.report_type   = REPORT_KEY;
    left_rep.modifier_bits = mods_w;
    left_rep.key_slots     = buf_w;

    rel_rep             = '0;
    rel_rep.report_type = REPORT_RELEASE;

    n_w = 2'(full_emit) + 2'(left_emit) + 2'(rel_emit);

    push.count = advance ? n_w : 2'd0;
    push.rep0  = full_emit ? full_rep : (left_emit ? left_rep : rel_rep);
    push.rep0.final_result = (n_w == 2'd1);
    push.rep1  = left_rep;
    push.rep1.final_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_buffer            <= '0;
      key_count             <= '0;
      modifier_acc          <= '0;
      any_pressed_this_scan <= 1'b0;
      pressed_last_scan     <= 1'b0;
    end else if (advance) begin
      if (item.last_column) begin
        key_buffer            <= '0;
        key_count             <= '0;
        modifier_acc          <= '0;
        any_pressed_this_scan <= 1'b0;
        pressed_last_scan     <= any_w;
      end else begin
        key_buffer            <= buf_w;
        key_count             <= cnt_w;
        modifier_acc          <= mods_w;
        any_pressed_this_scan <= any_w;
      end
    end
  end

endmodule

// ===== hdl/kmhr_out_fifo.sv =====
module kmhr_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  kmhr_pkg::push_t   push,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output kmhr_pkg::report_t head
);
  import kmhr_pkg::*;

  report_t              entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic [OUT_CNT_W-1:0] count_next;
  logic                 pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign room       = (count <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign head       = entries[rd_ptr];
  assign count_next = count + OUT_CNT_W'(push.count) - OUT_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.rep0;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= push.rep1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(push.count);
      rd_ptr <= rd_ptr + OUT_PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

// ===== hdl/key_matrix_hid_report_packer_unit.sv =====
// Keyboard matrix to HID boot report packer (six keys per report).
// Input channel (in_valid/in_ready): kind 0 writes keymap entry map_index
// with map_code; kind 1 carries row_bits of one column, last_column ending
// a full scan. Output channel (out_valid/out_ready): up to two HID reports
// per column item with report_type, modifier_bits, key_slot0..5 and
// final_result on the last report caused by a column item.
// Keymap writes take effect at acceptance and give no report. A column
// item is registered together with its keymap row read, then packed in
// one pass once the report queue has room and written into that queue,
// from which its first report is offered.
// Throughput: one item per cycle while the report queue has room; a
// column item yields at most two reports, which leave at one per cycle
// while out_ready is high, so the output port bounds the sustained rate.
// Reset clears the scan state and the report queue; the keymap is not
// cleared and must be written before use. When the receiver stalls, up to
// four reports queue and then in_ready drops until space frees up.
module key_matrix_hid_report_packer_unit #(
  parameter int COLUMNS = kmhr_pkg::KMHR_COLUMNS,
  parameter int ROWS    = kmhr_pkg::KMHR_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       kind,
  input  logic [6:0] map_index,
  input  logic [7:0] map_code,
  input  logic [3:0] column,
  input  logic [4:0] row_bits,
  input  logic       last_column,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       report_type,
  output logic [7:0] modifier_bits,
  output logic [7:0] key_slot0,
  output logic [7:0] key_slot1,
  output logic [7:0] key_slot2,
  output logic [7:0] key_slot3,
  output logic [7:0] key_slot4,
  output logic [7:0] key_slot5,
  output logic       final_result
);
  import kmhr_pkg::*;

  logic                 accept;
  logic                 s1_valid;
  col_item_t            s1_item;
  logic                 fire;
  logic                 room;
  logic [ROWS-1:0][7:0] codes;
  push_t                push;
  report_t              head;

  assign accept   = in_valid && in_ready;
  assign fire     = s1_valid && room;
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && (kind == KIND_COLUMN);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_COLUMN)) begin
      s1_item.row_bits    <= row_bits;
      s1_item.last_column <= last_column;
      s1_item.in_range    <= (6'(column) < 6'(COLUMNS));
    end
  end

  kmhr_keymap #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_keymap (
    .clk      (clk),
    .wr_en    (accept && (kind == KIND_MAP_WRITE)),
    .wr_index (map_index),
    .wr_code  (map_code),
    .rd_en    (accept && (kind == KIND_COLUMN)),
    .rd_column(column),
    .rd_codes (codes)
  );

  kmhr_core #(
    .ROWS(ROWS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .advance(fire),
    .item   (s1_item),
    .codes  (codes),
    .push   (push)
  );

  kmhr_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room     (room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign report_type   = head.report_type;
  assign modifier_bits = head.modifier_bits;
  assign key_slot0     = head.key_slots[0];
  assign key_slot1     = head.key_slots[1];
  assign key_slot2     = head.key_slots[2];
  assign key_slot3     = head.key_slots[3];
  assign key_slot4     = head.key_slots[4];
  assign key_slot5     = head.key_slots[5];
  assign final_result  = head.final_result;

endmodule

// ===== hdl/kmhr_checker.sv =====
`include "key_matrix_hid_report_packer_unit_macros.svh"

module kmhr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       report_type,
  input logic [7:0] modifier_bits,
  input logic [7:0] key_slot0,
  input logic [7:0] key_slot1,
  input logic [7:0] key_slot2,
  input logic [7:0] key_slot3,
  input logic [7:0] key_slot4,
  input logic [7:0] key_slot5,
  input logic       final_result
);

  `KMHR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(report_type)
    && $stable(modifier_bits) && $stable(key_slot0) && $stable(key_slot1)
    && $stable(key_slot2) && $stable(key_slot3) && $stable(key_slot4)
    && $stable(key_slot5) && $stable(final_result))
  `KMHR_ASSERT(a_release_empty, out_valid && report_type |-> modifier_bits == 8'h00
    && key_slot0 == 8'h00 && key_slot1 == 8'h00 && key_slot2 == 8'h00
    && key_slot3 == 8'h00 && key_slot4 == 8'h00 && key_slot5 == 8'h00)
  `KMHR_ASSERT(a_release_final, out_valid && report_type |-> final_result)
  `KMHR_ASSERT_RST(a_reset_empty, $past(rst) |-> !out_valid)

endmodule

bind key_matrix_hid_report_packer_unit kmhr_checker u_kmhr_checker (.*);
